// ----- design/rtg_pkg.sv -----
// ----------------------------------------------------------------------------
// rtg_pkg: shared types and constants
// Register indexes, the configuration struct and the CORDIC arctangent table
// for the turn-then-drive steering block.
// ----------------------------------------------------------------------------
package rtg_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_MAX_TURN_RATE   = 3'd0;
  localparam logic [2:0] REG_ARRIVE_DISTANCE = 3'd1;
  localparam logic [2:0] REG_SPEED_GAIN      = 3'd2;
  localparam logic [2:0] REG_SPEED_LIMIT     = 3'd3;
  localparam logic [2:0] REG_TURN_GAIN       = 3'd4;

  // Pre-rotation angle pi/2 and turn-in-place threshold pi/9, both Q3.12.
  localparam logic signed [15:0] HALF_PI_Q12    = 16'sd6434;
  localparam logic signed [15:0] BEAR_LIMIT_Q12 = 16'sd1430;

  // Widths of the CORDIC datapath and of the square root.
  localparam int unsigned CW       = 27;
  localparam int unsigned ZW       = 16;
  localparam int unsigned SQ_STEPS = 16;

  typedef struct packed {
    logic [14:0] max_turn_rate;
    logic [14:0] arrive_distance;
    logic [15:0] speed_gain;
    logic [14:0] speed_limit;
    logic [15:0] turn_gain;
  } cfg_t;

  // round(atan(2^-i) * 4096)
  function automatic logic signed [ZW-1:0] atan_q12(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    r = '0;
    case (i)
      5'd0:  r = 16'sd3217;
      5'd1:  r = 16'sd1899;
      5'd2:  r = 16'sd1003;
      5'd3:  r = 16'sd509;
      5'd4:  r = 16'sd256;
      5'd5:  r = 16'sd128;
      5'd6:  r = 16'sd64;
      5'd7:  r = 16'sd32;
      5'd8:  r = 16'sd16;
      5'd9:  r = 16'sd8;
      5'd10: r = 16'sd4;
      5'd11: r = 16'sd2;
      5'd12: r = 16'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/rtg_ifs.sv -----
// ----------------------------------------------------------------------------
// rtg_ifs: channel interfaces
// Goal input, command output and configuration write channels.
// ----------------------------------------------------------------------------
interface rtg_goal_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] goal_dx;
  logic signed [15:0] goal_dy;
  modport source (output valid, goal_dx, goal_dy, input ready);
  modport sink   (input valid, goal_dx, goal_dy, output ready);
endinterface

interface rtg_cmd_if;
  logic               valid;
  logic               ready;
  logic        [14:0] forward_speed;
  logic signed [15:0] turn_speed;
  logic               arrived;
  modport source (output valid, forward_speed, turn_speed, arrived, input ready);
  modport sink   (input valid, forward_speed, turn_speed, arrived, output ready);
endinterface

interface rtg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/rotate_then_go_waypoint_steer.sv -----
// ----------------------------------------------------------------------------
// rotate_then_go_waypoint_steer: turn-then-drive go-to-goal steering
// Turns a relative goal position into a forward speed and turn rate command.
// ----------------------------------------------------------------------------
// Usage:
// The goal channel takes one item per cycle unless stalled: the goal position
// in the robot frame as signed Q7.8 metres. Each item yields exactly one
// command item on the command channel: forward speed, turn rate and an
// arrived flag. The pipeline is three input stages (register, squares and
// pre-rotation, sum), max(16, CORDIC_STEPS) core stages, of which the first
// 16 each resolve one bit of the distance square root and the first CORDIC_STEPS
// each run one CORDIC step, and two command stages. The sustained rate is one
// item per cycle while the receiver does not stall.
// The whole pipeline advances together: when the receiver stalls with a
// command waiting, every stage holds and goal ready drops in the same cycle,
// so nothing is lost or repeated. Bubbles stay in place while the output waits.
// Configuration writes are always accepted and should be made while idle.
// Reset empties the pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
module rotate_then_go_waypoint_steer import rtg_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rtg_goal_if.sink  goal_i,
  rtg_cmd_if.source cmd_o,
  rtg_cfg_if.sink   cfg_i
);

  cfg_t                 cfg_q;
  logic                 adv;
  logic                 fv, cv;
  logic [31:0]          sum;
  logic signed [CW-1:0] fx, fy;
  logic signed [ZW-1:0] fz, alpha;
  logic [15:0]          goal_dist;

  // Configuration registers; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_turn_rate   <= 15'd256;
      cfg_q.arrive_distance <= 15'd26;
      cfg_q.speed_gain      <= 16'd1280;
      cfg_q.speed_limit     <= 15'd512;
      cfg_q.turn_gain       <= 16'd768;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_MAX_TURN_RATE:   cfg_q.max_turn_rate   <= cfg_i.data[14:0];
        REG_ARRIVE_DISTANCE: cfg_q.arrive_distance <= cfg_i.data[14:0];
        REG_SPEED_GAIN:      cfg_q.speed_gain      <= cfg_i.data;
        REG_SPEED_LIMIT:     cfg_q.speed_limit     <= cfg_i.data[14:0];
        REG_TURN_GAIN:       cfg_q.turn_gain       <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is empty or being taken.
  assign adv          = !cmd_o.valid || cmd_o.ready;
  assign goal_i.ready = adv;

  rtg_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (goal_i.valid),
    .dx_i    (goal_i.goal_dx),
    .dy_i    (goal_i.goal_dy),
    .valid_o (fv),
    .sum_o   (sum),
    .x_o     (fx),
    .y_o     (fy),
    .z_o     (fz)
  );

  rtg_core #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (fv),
    .sum_i   (sum),
    .x_i     (fx),
    .y_i     (fy),
    .z_i     (fz),
    .valid_o (cv),
    .dist_o  (goal_dist),
    .alpha_o (alpha)
  );

  rtg_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .cfg_i     (cfg_q),
    .valid_i   (cv),
    .dist_i    (goal_dist),
    .alpha_i   (alpha),
    .valid_o   (cmd_o.valid),
    .fwd_o     (cmd_o.forward_speed),
    .turn_o    (cmd_o.turn_speed),
    .arrived_o (cmd_o.arrived)
  );

  // An arrived command is a full stop.
  a_arrived_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.valid && cmd_o.arrived) |->
      (cmd_o.forward_speed == '0 && cmd_o.turn_speed == '0))
    else $error("arrived command is not a stop");

  // The forward speed never exceeds the configured limit.
  a_fwd_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.valid |-> (cmd_o.forward_speed <= cfg_q.speed_limit))
    else $error("forward speed above limit");

  // The turn rate stays within plus or minus the configured maximum.
  a_turn_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.valid |->
      ($signed({cmd_o.turn_speed[15], cmd_o.turn_speed}) <=
         $signed({2'b00, cfg_q.max_turn_rate}) &&
       $signed({cmd_o.turn_speed[15], cmd_o.turn_speed}) >=
         -$signed({2'b00, cfg_q.max_turn_rate})))
    else $error("turn rate outside limit");

  // A held command keeps the goal side stalled.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.valid && !cmd_o.ready) |-> !goal_i.ready)
    else $error("goal accepted while command stalled");

endmodule

// ----- design/rtg_front.sv -----
// ----------------------------------------------------------------------------
// rtg_front: input stages
// Registers the goal, squares both coordinates, sums the squares and
// pre-rotates the vector into the right half plane for the CORDIC.
// ----------------------------------------------------------------------------
module rtg_front import rtg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic signed [15:0]   dx_i,
  input  logic signed [15:0]   dy_i,
  output logic                 valid_o,
  output logic [31:0]          sum_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  logic                 va_q, vb_q, vc_q;
  logic signed [15:0]   dx_q, dy_q;
  logic [30:0]          sqx_q, sqy_q;
  logic signed [CW-1:0] xb_q, yb_q, xc_q, yc_q;
  logic signed [ZW-1:0] zb_q, zc_q;
  logic signed [31:0]   sqx_d, sqy_d;
  logic signed [CW-1:0] sx, sy, xb_d, yb_d;
  logic signed [ZW-1:0] zb_d;

  assign sqx_d = dx_q * dx_q;
  assign sqy_d = dy_q * dy_q;
  assign sx = {{(CW-24){dx_q[15]}}, dx_q, 8'h00};
  assign sy = {{(CW-24){dy_q[15]}}, dy_q, 8'h00};

  always_comb begin
    xb_d = sx;
    yb_d = sy;
    zb_d = '0;
    if (sx < 0) begin
      if (sy >= 0) begin
        xb_d = sy;
        yb_d = -sx;
        zb_d = HALF_PI_Q12;
      end else begin
        xb_d = -sy;
        yb_d = sx;
        zb_d = -HALF_PI_Q12;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (adv_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dx_q  <= dx_i;
      dy_q  <= dy_i;
      sqx_q <= sqx_d[30:0];
      sqy_q <= sqy_d[30:0];
      xb_q  <= xb_d;
      yb_q  <= yb_d;
      zb_q  <= zb_d;
      sum_o <= {1'b0, sqx_q} + {1'b0, sqy_q};
      xc_q  <= xb_q;
      yc_q  <= yb_q;
      zc_q  <= zb_q;
    end
  end

  assign valid_o = vc_q;
  assign x_o     = xc_q;
  assign y_o     = yc_q;
  assign z_o     = zc_q;

endmodule

// ----- design/rtg_core.sv -----
// ----------------------------------------------------------------------------
// rtg_core: square root and CORDIC pipeline
// Stages below SQ_STEPS resolve a root bit, below CORDIC_STEPS a CORDIC step.
// ----------------------------------------------------------------------------
module rtg_core import rtg_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic [31:0]          sum_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic                 valid_o,
  output logic [15:0]          dist_o,
  output logic signed [ZW-1:0] alpha_o
);

  localparam int unsigned NS = (CORDIC_STEPS > SQ_STEPS) ? CORDIC_STEPS : SQ_STEPS;

  logic                 v_q   [NS];
  logic [31:0]          rem_q [NS];
  logic [15:0]          root_q[NS];
  logic signed [CW-1:0] x_q   [NS];
  logic signed [CW-1:0] y_q   [NS];
  logic signed [ZW-1:0] z_q   [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic                 v_in;
    logic [31:0]          rem_in, rem_d;
    logic [15:0]          root_in, root_d;
    logic signed [CW-1:0] x_in, y_in, x_d, y_d, xs, ys;
    logic signed [ZW-1:0] z_in, z_d;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = sum_i;
      assign root_in = '0;
      assign x_in    = x_i;
      assign y_in    = y_i;
      assign z_in    = z_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign x_in    = x_q[s-1];
      assign y_in    = y_q[s-1];
      assign z_in    = z_q[s-1];
    end

    // One bit of the restoring square root, most significant first.
    if (s < SQ_STEPS) begin : g_sqrt
      localparam int unsigned K = SQ_STEPS - 1 - s;
      logic [33:0] trial;
      assign trial = ({18'd0, root_in} << (K + 1)) | (34'd1 << (2 * K));
      always_comb begin
        rem_d  = rem_in;
        root_d = root_in;
        if ({2'b00, rem_in} >= trial) begin
          rem_d  = rem_in - trial[31:0];
          root_d = root_in | (16'd1 << K);
        end
      end
    end else begin : g_sqrt_pass
      assign rem_d  = rem_in;
      assign root_d = root_in;
    end

    // One CORDIC vectoring step; arithmetic shifts round toward minus infinity.
    if (s < CORDIC_STEPS) begin : g_cordic
      assign xs = x_in >>> s;
      assign ys = y_in >>> s;
      always_comb begin
        if (y_in > 0) begin
          x_d = x_in + ys;
          y_d = y_in - xs;
          z_d = z_in + atan_q12(5'(s));
        end else begin
          x_d = x_in - ys;
          y_d = y_in + xs;
          z_d = z_in - atan_q12(5'(s));
        end
      end
    end else begin : g_cordic_pass
      assign xs  = x_in;
      assign ys  = y_in;
      assign x_d = xs;
      assign y_d = ys;
      assign z_d = z_in;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (adv_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        x_q[s]    <= x_d;
        y_q[s]    <= y_d;
        z_q[s]    <= z_d;
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign dist_o  = root_q[NS-1];
  assign alpha_o = z_q[NS-1];

endmodule

// ----- design/rtg_back.sv -----
// ----------------------------------------------------------------------------
// rtg_back: command stages
// Scales distance and bearing by the gains, then saturates, clamps and
// picks the arrived, turn-in-place or drive command into the output register.
// ----------------------------------------------------------------------------
module rtg_back import rtg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  cfg_t                 cfg_i,
  input  logic                 valid_i,
  input  logic [15:0]          dist_i,
  input  logic signed [ZW-1:0] alpha_i,
  output logic                 valid_o,
  output logic [14:0]          fwd_o,
  output logic signed [15:0]   turn_o,
  output logic                 arrived_o
);

  logic               vd_q, ve_q;
  logic [31:0]        fprod_q;
  logic signed [32:0] tprod_q;
  logic               arr_q, big_q, pos_q;
  logic [14:0]        fwd_d;
  logic signed [15:0] turn_d;
  logic               arr_d;
  logic [23:0]        fsh;
  logic signed [20:0] tsh, lim;

  assign fsh = fprod_q[31:8];
  assign tsh = tprod_q[32:12];
  assign lim = {6'd0, cfg_i.max_turn_rate};

  always_comb begin
    fwd_d  = '0;
    turn_d = '0;
    arr_d  = 1'b0;
    if (arr_q) begin
      arr_d = 1'b1;
    end else if (big_q) begin
      turn_d = pos_q ? lim[15:0] : 16'(-lim);
    end else begin
      fwd_d = (fsh > {9'd0, cfg_i.speed_limit}) ? cfg_i.speed_limit : fsh[14:0];
      if (tsh > lim) begin
        turn_d = lim[15:0];
      end else if (tsh < -lim) begin
        turn_d = 16'(-lim);
      end else begin
        turn_d = tsh[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (adv_i) begin
      vd_q <= valid_i;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fprod_q   <= cfg_i.speed_gain * dist_i;
      tprod_q   <= $signed({1'b0, cfg_i.turn_gain}) * alpha_i;
      arr_q     <= dist_i <= {1'b0, cfg_i.arrive_distance};
      big_q     <= (alpha_i > BEAR_LIMIT_Q12) || (alpha_i < -BEAR_LIMIT_Q12);
      pos_q     <= alpha_i > 0;
      fwd_o     <= fwd_d;
      turn_o    <= turn_d;
      arrived_o <= arr_d;
    end
  end

  assign valid_o = ve_q;

endmodule
